// ----- src/ffha_pkg.sv -----
// Package for the first-fit heap allocator: widths, codes and shared types.
// No dependencies; every other file imports it.
package ffha_pkg;

  localparam int DEF_MAX_SEGMENTS    = 256;
  localparam int DEF_HEADER_BYTES    = 24;
  localparam int SPLIT_MIN_REMAINDER = 24;
  localparam int SZ_W                = 25;
  localparam int ADDR_W              = 32;
  localparam int REQ_W               = 24;
  localparam int STATUS_W            = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_FIT     = 2'd1,
    ST_BAD_FREE   = 2'd2,
    ST_TABLE_FULL = 2'd3
  } status_t;

  typedef enum logic {
    CFG_REGION_BASE  = 1'b0,
    CFG_REGION_BYTES = 1'b1
  } cfg_index_t;

  typedef enum logic {
    KIND_ALLOC = 1'b0,
    KIND_FREE  = 1'b1
  } kind_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    alu_op_t           op;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic init;
    logic pop;
    logic push;
  } pool_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_TGT, S_CHK,
    S_A_SPL, S_A_W0, S_A_W1, S_A_W2, S_GRANT,
    S_F0, S_F1, S_F2, S_F3, S_F4, S_F5,
    S_RESP
  } state_t;

endpackage

// ----- src/ffha_if.sv -----
// Request and response channel interfaces of the heap allocator.
// Depends on ffha_pkg for field widths.
interface ffha_req_if import ffha_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [REQ_W-1:0]  request_bytes;
  logic [ADDR_W-1:0] block_address;
  modport source (output valid, kind, request_bytes, block_address, input ready);
  modport sink (input valid, kind, request_bytes, block_address, output ready);
endinterface

interface ffha_rsp_if import ffha_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   granted_address;
  logic [STATUS_W-1:0] status;
  modport source (output valid, granted_address, status, input ready);
  modport sink (input valid, granted_address, status, output ready);
endinterface

// ----- src/ffha_alu.sv -----
// Shared add/subtract unit used by the sequencer for size and address sums.
// Depends on ffha_pkg for alu_req_t.
module ffha_alu import ffha_pkg::*; (
  input  alu_req_t          req,
  output logic [ADDR_W-1:0] res,
  output logic              borrow
);

  logic [ADDR_W:0] sum;

  // Add, or subtract by two's complement; borrow flags a < b
  always_comb begin
    if (req.op == ALU_SUB) begin
      sum = {1'b0, req.a} + {1'b0, ~req.b} + {{ADDR_W{1'b0}}, 1'b1};
    end else begin
      sum = {1'b0, req.a} + {1'b0, req.b};
    end
  end

  assign res    = sum[ADDR_W-1:0];
  assign borrow = (req.op == ALU_SUB) && !sum[ADDR_W];

endmodule

// ----- src/ffha_seg_mem.sv -----
// Segment table memory: one write port, one read port with registered data.
// Depends on ffha_pkg for the default depth.
module ffha_seg_mem import ffha_pkg::*; #(
  parameter int DEPTH = DEF_MAX_SEGMENTS,
  parameter int WIDTH = 8,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/ffha_slot_pool.sv -----
// Pool of unused table slots: a high-water mark plus a stack of released slots.
// Depends on ffha_pkg for pool_ctl_t.
module ffha_slot_pool import ffha_pkg::*; #(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int IDX_W        = 8,
  parameter int LINK_W       = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  pool_ctl_t        ctl,
  input  logic [IDX_W-1:0] push_idx,
  output logic             avail,
  output logic [IDX_W-1:0] slot
);

  logic [IDX_W-1:0]  stack [MAX_SEGMENTS];
  logic [LINK_W-1:0] sp;
  logic [LINK_W-1:0] hw;
  logic [LINK_W-1:0] sp_dec;

  assign sp_dec = sp - LINK_W'(1);
  assign avail  = (sp != '0) || (hw != LINK_W'(MAX_SEGMENTS));

  // Track stack depth and high-water mark; slot 0 is always taken
  always_ff @(posedge clk) begin
    if (rst || ctl.init) begin
      sp <= '0;
      hw <= LINK_W'(1);
    end else if (ctl.push) begin
      sp <= sp + LINK_W'(1);
    end else if (ctl.pop) begin
      if (sp != '0) begin
        sp <= sp_dec;
      end else begin
        hw <= hw + LINK_W'(1);
      end
    end
  end

  // Push released slots
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      stack[sp[IDX_W-1:0]] <= push_idx;
    end
  end

  // Hand out a released slot first, else the next never-used one
  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      if (sp != '0) begin
        slot <= stack[sp_dec[IDX_W-1:0]];
      end else begin
        slot <= hw[IDX_W-1:0];
      end
    end
  end

endmodule

// ----- src/first_fit_heap_allocator.sv -----
// First-fit heap allocator over a linked segment table in one memory.
// The walk visits one segment per cycle, at most MAX_SEGMENTS, before the split
// or merge writes. One request at a time: a new one is taken only while idle,
// after the previous response has been accepted. Reset or a config write while
// idle rebuilds slot 0 as one free segment over the region in the next cycle;
// requests are refused in the write cycle and in that cycle.
module first_fit_heap_allocator import ffha_pkg::*; #(
  parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS,
  parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [ADDR_W-1:0] cfg_data,
  ffha_req_if.sink          req,
  ffha_rsp_if.source        rsp
);

  localparam int LINK_W = $clog2(MAX_SEGMENTS + 1);
  localparam int IDX_W  = $clog2(MAX_SEGMENTS);
  localparam logic [LINK_W-1:0] NIL = LINK_W'(MAX_SEGMENTS);

  typedef struct packed {
    logic [SZ_W-1:0]   offset;
    logic [SZ_W-1:0]   size;
    logic              free;
    logic [LINK_W-1:0] next;
    logic [LINK_W-1:0] prev;
  } seg_rec_t;

  localparam int REC_W = $bits(seg_rec_t);

  // Configuration
  logic [ADDR_W-1:0] region_base;
  logic [SZ_W-1:0]   region_bytes;

  // Sequencer and request registers
  state_t            state, state_next;
  logic              kind_q;
  logic [SZ_W-1:0]   need;
  logic [ADDR_W-1:0] addr_m;
  logic [ADDR_W-1:0] target;
  logic [LINK_W-1:0] cur;
  seg_rec_t          cur_rec;
  logic [SZ_W-1:0]   rem;
  logic              split;
  logic [SZ_W-1:0]   new_off;
  logic [IDX_W-1:0]  new_slot;
  logic [ADDR_W-1:0] granted;
  status_t           status_q;

  // Datapath controls
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;
  seg_rec_t          mem_wrec;
  logic [REC_W-1:0]  mem_rdata;
  seg_rec_t          rec_rd;
  alu_req_t          alu_req;
  logic [ADDR_W-1:0] alu_res;
  logic              alu_borrow;
  pool_ctl_t         pool_ctl;
  logic [IDX_W-1:0]  push_idx;
  logic              pool_avail;
  logic [IDX_W-1:0]  pool_slot;
  logic              accept;
  logic              match;
  logic              split_now;

  assign rec_rd    = seg_rec_t'(mem_rdata);
  assign req.ready = (state == S_IDLE) && !cfg_we;
  assign accept    = req.valid && req.ready;
  assign split_now = alu_res[SZ_W-1:0] > SZ_W'(SPLIT_MIN_REMAINDER);
  assign match     = (kind_q == KIND_FREE) ? (ADDR_W'(rec_rd.offset) == target)
                                           : (rec_rd.free && !alu_borrow);

  assign rsp.valid           = (state == S_RESP);
  assign rsp.granted_address = granted;
  assign rsp.status          = status_q;

  ffha_alu u_alu (
    .req    (alu_req),
    .res    (alu_res),
    .borrow (alu_borrow)
  );

  ffha_seg_mem #(
    .DEPTH (MAX_SEGMENTS),
    .WIDTH (REC_W),
    .AW    (IDX_W)
  ) u_seg_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wrec),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ffha_slot_pool #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .IDX_W        (IDX_W),
    .LINK_W       (LINK_W)
  ) u_slot_pool (
    .clk      (clk),
    .rst      (rst),
    .ctl      (pool_ctl),
    .push_idx (push_idx),
    .avail    (pool_avail),
    .slot     (pool_slot)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      region_base  <= '0;
      region_bytes <= SZ_W'(1 << REQ_W);
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_REGION_BASE:  region_base  <= cfg_data;
        CFG_REGION_BYTES: region_bytes <= cfg_data[SZ_W-1:0];
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cfg_we) begin
          state_next = S_INIT;
        end else if (accept) begin
          state_next = S_TGT;
        end
      end
      S_INIT:  state_next = cfg_we ? S_INIT : S_IDLE;
      S_TGT:   state_next = S_CHK;
      S_CHK: begin
        if (match) begin
          if (kind_q == KIND_FREE) begin
            state_next = S_F0;
          end else begin
            state_next = split_now ? S_A_SPL : S_A_W1;
          end
        end else if (rec_rd.next == NIL) begin
          state_next = S_RESP;
        end
      end
      S_A_SPL: state_next = pool_avail ? S_A_W0 : S_RESP;
      S_A_W0:  state_next = S_A_W1;
      S_A_W1:  state_next = (split && cur_rec.next != NIL) ? S_A_W2 : S_GRANT;
      S_A_W2:  state_next = S_GRANT;
      S_GRANT: state_next = S_RESP;
      S_F0:    state_next = (cur_rec.next != NIL) ? S_F1 : S_F3;
      S_F1:    state_next = (rec_rd.free && rec_rd.next != NIL) ? S_F2 : S_F3;
      S_F2:    state_next = S_F3;
      S_F3:    state_next = (cur_rec.prev != NIL) ? S_F4 : S_RESP;
      S_F4:    state_next = (rec_rd.free && cur_rec.next != NIL) ? S_F5 : S_RESP;
      S_F5:    state_next = S_RESP;
      S_RESP:  state_next = rsp.ready ? S_IDLE : S_RESP;
      default: state_next = S_IDLE;
    endcase
  end

  // Memory, unit and pool controls per state
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wrec  = cur_rec;
    mem_re    = 1'b0;
    mem_raddr = '0;
    alu_req   = '{op: ALU_ADD, a: '0, b: '0};
    pool_ctl  = '{init: 1'b0, pop: 1'b0, push: 1'b0};
    push_idx  = '0;
    unique case (state)
      S_INIT: begin
        mem_we   = 1'b1;
        mem_wrec = '{offset: '0, size: region_bytes, free: 1'b1, next: NIL, prev: NIL};
        pool_ctl.init = 1'b1;
      end
      S_TGT: begin
        alu_req = '{op: ALU_SUB, a: addr_m, b: region_base};
        mem_re  = 1'b1;
      end
      S_CHK: begin
        alu_req = '{op: ALU_SUB, a: ADDR_W'(rec_rd.size), b: ADDR_W'(need)};
        if (!match && rec_rd.next != NIL) begin
          mem_re    = 1'b1;
          mem_raddr = rec_rd.next[IDX_W-1:0];
        end
      end
      S_A_SPL: begin
        alu_req = '{op: ALU_ADD, a: ADDR_W'(cur_rec.offset), b: ADDR_W'(need)};
        pool_ctl.pop = pool_avail;
      end
      S_A_W0: begin
        mem_we    = 1'b1;
        mem_waddr = pool_slot;
        mem_wrec  = '{offset: new_off, size: rem, free: 1'b1,
                      next: cur_rec.next, prev: cur};
        if (cur_rec.next != NIL) begin
          mem_re    = 1'b1;
          mem_raddr = cur_rec.next[IDX_W-1:0];
        end
      end
      S_A_W1: begin
        mem_we    = 1'b1;
        mem_waddr = cur[IDX_W-1:0];
        mem_wrec  = cur_rec;
        mem_wrec.free = 1'b0;
        if (split) begin
          mem_wrec.size = need;
          mem_wrec.next = LINK_W'(new_slot);
        end
      end
      S_A_W2: begin
        mem_we    = 1'b1;
        mem_waddr = cur_rec.next[IDX_W-1:0];
        mem_wrec  = rec_rd;
        mem_wrec.prev = LINK_W'(new_slot);
      end
      S_GRANT: begin
        alu_req = '{op: ALU_ADD, a: region_base,
                    b: ADDR_W'(cur_rec.offset) + ADDR_W'(HEADER_BYTES)};
      end
      S_F0: begin
        if (cur_rec.next != NIL) begin
          mem_re    = 1'b1;
          mem_raddr = cur_rec.next[IDX_W-1:0];
        end
      end
      S_F1: begin
        alu_req = '{op: ALU_ADD, a: ADDR_W'(cur_rec.size), b: ADDR_W'(rec_rd.size)};
        if (rec_rd.free) begin
          pool_ctl.push = 1'b1;
          push_idx      = cur_rec.next[IDX_W-1:0];
          if (rec_rd.next != NIL) begin
            mem_re    = 1'b1;
            mem_raddr = rec_rd.next[IDX_W-1:0];
          end
        end
      end
      S_F2: begin
        mem_we    = 1'b1;
        mem_waddr = cur_rec.next[IDX_W-1:0];
        mem_wrec  = rec_rd;
        mem_wrec.prev = cur;
      end
      S_F3: begin
        if (cur_rec.prev != NIL) begin
          mem_re    = 1'b1;
          mem_raddr = cur_rec.prev[IDX_W-1:0];
        end else begin
          mem_we    = 1'b1;
          mem_waddr = cur[IDX_W-1:0];
        end
      end
      S_F4: begin
        alu_req = '{op: ALU_ADD, a: ADDR_W'(rec_rd.size), b: ADDR_W'(cur_rec.size)};
        mem_we  = 1'b1;
        if (rec_rd.free) begin
          mem_waddr     = cur_rec.prev[IDX_W-1:0];
          mem_wrec      = rec_rd;
          mem_wrec.size = alu_res[SZ_W-1:0];
          mem_wrec.next = cur_rec.next;
          pool_ctl.push = 1'b1;
          push_idx      = cur[IDX_W-1:0];
          if (cur_rec.next != NIL) begin
            mem_re    = 1'b1;
            mem_raddr = cur_rec.next[IDX_W-1:0];
          end
        end else begin
          mem_waddr = cur[IDX_W-1:0];
        end
      end
      S_F5: begin
        mem_we    = 1'b1;
        mem_waddr = cur_rec.next[IDX_W-1:0];
        mem_wrec  = rec_rd;
        mem_wrec.prev = cur_rec.prev;
      end
      default: ;
    endcase
  end

  // Request and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      status_q <= ST_OK;
      granted  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            kind_q   <= req.kind;
            need     <= SZ_W'(req.request_bytes) + SZ_W'(HEADER_BYTES);
            addr_m   <= req.block_address - ADDR_W'(HEADER_BYTES);
            cur      <= '0;
            granted  <= '0;
            status_q <= ST_OK;
          end
        end
        S_TGT: target <= alu_res;
        S_CHK: begin
          if (match) begin
            cur_rec <= rec_rd;
            rem     <= alu_res[SZ_W-1:0];
            split   <= split_now;
          end else if (rec_rd.next != NIL) begin
            cur <= rec_rd.next;
          end else begin
            status_q <= (kind_q == KIND_FREE) ? ST_BAD_FREE : ST_NO_FIT;
          end
        end
        S_A_SPL: begin
          new_off <= alu_res[SZ_W-1:0];
          if (!pool_avail) begin
            status_q <= ST_TABLE_FULL;
          end
        end
        S_A_W0:  new_slot <= pool_slot;
        S_GRANT: granted <= alu_res;
        S_F0:    cur_rec.free <= 1'b1;
        S_F1: begin
          if (rec_rd.free) begin
            cur_rec.size <= alu_res[SZ_W-1:0];
            cur_rec.next <= rec_rd.next;
          end
        end
        default: ;
      endcase
    end
  end

  // A request is never taken while a response is pending
  assert property (@(posedge clk) disable iff (rst) req.ready |-> !rsp.valid)
    else $error("request accepted with response pending");

  // Only a successful allocate carries an address
  assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |-> rsp.granted_address == '0)
    else $error("address given with failure status");

  // An accepted request starts the walk
  assert property (@(posedge clk) disable iff (rst) accept |=> state == S_TGT)
    else $error("accepted request not started");

  // Slot pool is never pushed and popped together
  assert property (@(posedge clk) disable iff (rst) !(pool_ctl.push && pool_ctl.pop))
    else $error("slot pool push and pop collide");

endmodule

// ----- dv/tb_first_fit_heap_allocator.sv -----
// Self-checking testbench for first_fit_heap_allocator: directed and random
// allocate/free traffic against an in-bench segment table predictor.
// Depends on ffha_pkg, ffha_if and the allocator RTL.
module tb_first_fit_heap_allocator;
  import ffha_pkg::*;

  localparam int SEGS = DEF_MAX_SEGMENTS;
  localparam int HDR  = DEF_HEADER_BYTES;
  localparam int NIL  = DEF_MAX_SEGMENTS;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    status_t           status;
  } grant_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic              cfg_index;
  logic [ADDR_W-1:0] cfg_data;

  ffha_req_if req ();
  ffha_rsp_if rsp ();

  first_fit_heap_allocator u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req.sink),
    .rsp       (rsp.source)
  );

  // Predicted allocator state
  logic [31:0] heap_base;
  logic [31:0] heap_bytes;
  logic [31:0] seg_off   [SEGS];
  logic [31:0] seg_size  [SEGS];
  bit          seg_free  [SEGS];
  int          seg_next  [SEGS];
  int          seg_prev  [SEGS];
  bit          slot_used [SEGS];

  grant_t      pending_grants[$];
  logic [31:0] live_blocks[$];
  int          mismatches;
  int          n_grant, n_no_fit, n_bad_free, n_full, n_freed;
  bit          quiet;
  int          rx_hold;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void drop_slot(int s);
    slot_used[s] = 0;
    seg_free[s]  = 0;
    seg_size[s]  = '0;
    seg_off[s]   = '0;
    seg_next[s]  = NIL;
    seg_prev[s]  = NIL;
  endfunction

  function automatic void rebuild_heap();
    for (int i = 0; i < SEGS; i++) drop_slot(i);
    slot_used[0] = 1;
    seg_free[0]  = 1;
    seg_size[0]  = heap_bytes;
    live_blocks.delete();
  endfunction

  function automatic int lowest_idle_slot();
    for (int i = 0; i < SEGS; i++)
      if (!slot_used[i]) return i;
    return NIL;
  endfunction

  // First-fit search with split when the remainder exceeds the minimum
  function automatic grant_t predict_alloc(logic [23:0] bytes);
    grant_t      g;
    logic [31:0] need;
    int          cur, s, nx;
    g.addr   = '0;
    g.status = ST_NO_FIT;
    need     = 32'(bytes) + HDR;
    cur      = 0;
    for (int n = 0; n < SEGS && cur < NIL; n++) begin
      if (seg_free[cur] && seg_size[cur] >= need) begin
        if (seg_size[cur] - need > SPLIT_MIN_REMAINDER) begin
          s  = lowest_idle_slot();
          nx = seg_next[cur];
          if (s >= NIL) begin
            g.status = ST_TABLE_FULL;
            return g;
          end
          slot_used[s]  = 1;
          seg_free[s]   = 1;
          seg_off[s]    = seg_off[cur] + need;
          seg_size[s]   = seg_size[cur] - need;
          seg_size[cur] = need;
          seg_next[s]   = nx;
          if (nx < NIL) seg_prev[nx] = s;
          seg_next[cur] = s;
          seg_prev[s]   = cur;
        end
        seg_free[cur] = 0;
        g.status      = ST_OK;
        g.addr        = heap_base + seg_off[cur] + HDR;
        return g;
      end
      cur = seg_next[cur];
    end
    return g;
  endfunction

  // Match segment start, mark free, merge with next then previous
  function automatic grant_t predict_free(logic [31:0] addr);
    grant_t      g;
    logic [31:0] target;
    int          cur, nx, pv, after;
    g.addr   = '0;
    g.status = ST_BAD_FREE;
    target   = addr - HDR - heap_base;
    cur      = 0;
    for (int n = 0; n < SEGS && cur < NIL; n++) begin
      if (seg_off[cur] == target) begin
        nx = seg_next[cur];
        seg_free[cur] = 1;
        if (nx < NIL && seg_free[nx]) begin
          after = seg_next[nx];
          seg_size[cur] += seg_size[nx];
          seg_next[cur] = after;
          if (after < NIL) seg_prev[after] = cur;
          drop_slot(nx);
        end
        pv = seg_prev[cur];
        if (pv < NIL && seg_free[pv]) begin
          after = seg_next[cur];
          seg_size[pv] += seg_size[cur];
          seg_next[pv] = after;
          if (after < NIL) seg_prev[after] = pv;
          drop_slot(cur);
        end
        g.status = ST_OK;
        return g;
      end
      cur = seg_next[cur];
    end
    return g;
  endfunction

  // Drive one request, hold until accepted, then predict and maybe gap
  task automatic send_request(kind_t k, logic [23:0] bytes, logic [31:0] addr);
    grant_t g;
    int     gap;
    req.valid         <= 1'b1;
    req.kind          <= k;
    req.request_bytes <= bytes;
    req.block_address <= addr;
    do @(posedge clk); while (!req.ready);
    if (k == KIND_ALLOC) begin
      g = predict_alloc(bytes);
      case (g.status)
        ST_OK:         begin n_grant++; live_blocks.push_back(g.addr); end
        ST_NO_FIT:     n_no_fit++;
        ST_TABLE_FULL: n_full++;
        default: ;
      endcase
    end else begin
      g = predict_free(addr);
      if (g.status == ST_OK) begin
        n_freed++;
        foreach (live_blocks[i])
          if (live_blocks[i] == addr) begin
            live_blocks.delete(i);
            break;
          end
      end else begin
        n_bad_free++;
      end
    end
    pending_grants.push_back(g);
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic park_sender();
    req.valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_index_t idx, logic [31:0] value);
    park_sender();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_REGION_BASE) heap_base = value;
    else heap_bytes = value & 32'h1FF_FFFF;
    rebuild_heap();
  endtask

  task automatic free_live(int idx);
    send_request(KIND_FREE, 24'($urandom), live_blocks[idx]);
  endtask

  // Response side: check each accepted response, apply random stalls
  initial begin
    grant_t exp_g;
    int     stall;
    stall     = 0;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp.valid && rsp.ready) begin
        if (pending_grants.size() == 0) begin
          $error("unexpected response: granted_address=%h status=%0d",
                 rsp.granted_address, rsp.status);
          mismatches++;
        end else begin
          exp_g = pending_grants.pop_front();
          if (rsp.granted_address !== exp_g.addr) begin
            $error("granted_address: expected %h, actual %h", exp_g.addr,
                   rsp.granted_address);
            mismatches++;
          end
          if (rsp.status !== exp_g.status) begin
            $error("status: expected %0d, actual %0d", exp_g.status, rsp.status);
            mismatches++;
          end
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        rsp.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 4) == 0) stall = $urandom_range(1, 4);
      end
    end
  end

  // Field extremes, bad and double frees at reset config, then exact fit
  task automatic test_directed();
    logic [31:0] a0, a1;
    send_request(KIND_ALLOC, 24'd0, 32'h0);
    send_request(KIND_ALLOC, 24'hFF_FFFF, 32'hFFFF_FFFF);
    send_request(KIND_ALLOC, 24'd100, 32'h0);
    send_request(KIND_ALLOC, 24'd40, 32'h0);
    a0 = live_blocks[1];
    a1 = live_blocks[2];
    send_request(KIND_FREE, 24'h0, 32'h0);
    send_request(KIND_FREE, 24'h0, 32'hFFFF_FFFF);
    send_request(KIND_FREE, 24'hFF_FFFF, a0);
    send_request(KIND_FREE, 24'h0, a0);
    send_request(KIND_FREE, 24'h0, a1);
    send_request(KIND_FREE, 24'h0, 32'd24);
    // exact fit leaves no split remainder
    write_cfg(CFG_REGION_BYTES, 32'd1000);
    send_request(KIND_ALLOC, 24'd960, 32'h0);
    send_request(KIND_ALLOC, 24'd1, 32'h0);
    send_request(KIND_FREE, 24'h0, 32'd24);
    send_request(KIND_ALLOC, 24'd952, 32'h0);
    send_request(KIND_ALLOC, 24'd0, 32'h0);
    park_sender();
  endtask

  // Register extremes: wrapped base, empty region, full region
  task automatic test_config_extremes();
    write_cfg(CFG_REGION_BASE, 32'hFFFF_FFF0);
    send_request(KIND_ALLOC, 24'd64, 32'h0);
    send_request(KIND_FREE, 24'h0, live_blocks[0]);
    write_cfg(CFG_REGION_BYTES, 32'd0);
    send_request(KIND_ALLOC, 24'd0, 32'h0);
    send_request(KIND_FREE, 24'h0, 32'hFFFF_FFF0 + HDR);
    write_cfg(CFG_REGION_BYTES, 32'h100_0000);
    write_cfg(CFG_REGION_BASE, 32'h0);
    send_request(KIND_ALLOC, 24'hFF_FFE8, 32'h0);
    send_request(KIND_ALLOC, 24'd0, 32'h0);
    park_sender();
  endtask

  // Fill every slot with small blocks until the table runs out, then free and reallocate some
  task automatic test_table_full();
    write_cfg(CFG_REGION_BASE, 32'h8000_0000);
    write_cfg(CFG_REGION_BYTES, 32'd20000);
    while (n_full < 4) send_request(KIND_ALLOC, 24'($urandom_range(0, 16)), 32'h0);
    repeat (20) free_live($urandom_range(0, live_blocks.size() - 1));
    repeat (10) send_request(KIND_ALLOC, 24'($urandom_range(0, 40)), 32'h0);
    park_sender();
  endtask

  // Long receiver hold-off while requests keep coming, then sender pause
  task automatic test_backpressure();
    rx_hold = 150;
    repeat (6) send_request(KIND_ALLOC, 24'($urandom_range(0, 300)), 32'h0);
    park_sender();
  endtask

  // Mostly well-formed alloc/free traffic with some noise
  task automatic test_random(int count);
    int      pick;
    logic [23:0] sz;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50 || live_blocks.size() == 0) begin
        case ($urandom_range(0, 9))
          0:       sz = 24'($urandom);
          1, 2, 3: sz = 24'($urandom_range(0, 4000));
          default: sz = 24'($urandom_range(0, 200));
        endcase
        send_request(KIND_ALLOC, sz, $urandom);
      end else if (pick < 90) begin
        free_live($urandom_range(0, live_blocks.size() - 1));
      end else begin
        send_request(KIND_FREE, 24'($urandom), (pick < 95) ? 32'($urandom)
                     : 32'(heap_base + HDR + $urandom_range(0, 64)));
      end
    end
  endtask

  initial begin
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = CFG_REGION_BASE;
    cfg_data          = '0;
    req.valid         = 1'b0;
    req.kind          = KIND_ALLOC;
    req.request_bytes = '0;
    req.block_address = '0;
    mismatches = 0;
    n_grant = 0; n_no_fit = 0; n_bad_free = 0; n_full = 0; n_freed = 0;
    quiet      = 0;
    rx_hold    = 0;
    heap_base  = '0;
    heap_bytes = 32'h100_0000;
    rebuild_heap();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    test_directed();
    test_config_extremes();
    test_table_full();
    test_backpressure();
    write_cfg(CFG_REGION_BASE, 32'h1234_5678);
    write_cfg(CFG_REGION_BYTES, 32'd65536);
    test_random(300);
    write_cfg(CFG_REGION_BASE, 32'hFFFF_0000);
    write_cfg(CFG_REGION_BYTES, 32'd8000);
    test_random(250);
    // final stretch with no idling on either side
    write_cfg(CFG_REGION_BYTES, 32'h100_0000);
    quiet = 1;
    test_random(250);
    park_sender();
    repeat (300) @(posedge clk);

    $display("Covered %0d grants, %0d frees, %0d no-fit, %0d bad-free, %0d table-full",
             n_grant, n_freed, n_no_fit, n_bad_free, n_full);
    $display("across several region settings; %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
